// ===== design/scsa_pkg.sv =====
package scsa_pkg;

    // Default configuration of the allocator.
    localparam int unsigned NUM_CLASSES_DEF  = 10;
    localparam int unsigned REGION_BYTES_DEF = 1024;

    // Field widths of the request and response beats.
    localparam int unsigned SIZE_W = 12;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned STAT_W = 3;

    // Occupancy bitmap word width, and the width used for slot counts.
    localparam int unsigned BM_W  = 32;
    localparam int unsigned CNT_W = 16;

    localparam logic [ADDR_W-1:0] SLAB_BASE = 32'h2000_0000;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_CLASS  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NULL      = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic [STAT_W-1:0] status;
    } rsp_t;

    // Class c holds objects of 2^(c+1) bytes.
    function automatic int unsigned slots_in_class(int unsigned region, int unsigned c);
        return region >> (c + 1);
    endfunction

    function automatic int unsigned first_slot(int unsigned region, int unsigned c);
        int unsigned base;
        base = 0;
        for (int unsigned k = 0; k < c; k++)
        begin
            base += slots_in_class(region, k);
        end
        return base;
    endfunction

    function automatic int unsigned class_words(int unsigned region, int unsigned c);
        return (slots_in_class(region, c) + BM_W - 1) / BM_W;
    endfunction

    function automatic int unsigned word_base(int unsigned region, int unsigned c);
        int unsigned base;
        base = 0;
        for (int unsigned k = 0; k < c; k++)
        begin
            base += class_words(region, k);
        end
        return base;
    endfunction

    // Marks the slots of a bitmap word that exist, given how many slots
    // of the class remain from the first bit of that word.
    function automatic logic [BM_W-1:0] mask_from_rem(logic [CNT_W-1:0] rem);
        logic [BM_W-1:0] m;
        for (int unsigned i = 0; i < BM_W; i++)
        begin
            m[i] = (rem > CNT_W'(i));
        end
        return m;
    endfunction

endpackage

// ===== design/size_class_slot_allocator_top.sv =====
// A request beat that reaches the slot memory passes through the decode, lookup
// and finish states before rsp_valid rises, with the bitmap read and the slot
// memory read-modify-write between them; one that ends in an error skips lookup.
// A new request is taken only back in the idle state, once the last response has
// been loaded, so requests are served one at a time. Reset (rst_n, asynchronous,
// active low) starts a fill pass that writes the carved addresses, one slot per cycle.
module size_class_slot_allocator_top #(
    parameter int unsigned NUM_CLASSES  = scsa_pkg::NUM_CLASSES_DEF,
    parameter int unsigned REGION_BYTES = scsa_pkg::REGION_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  scsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output scsa_pkg::rsp_t rsp
);

    // Slot storage is one memory of REGION_BYTES addresses, with class c
    // occupying a contiguous run. Beside it sits an occupancy bitmap memory
    // in which every class starts on a fresh word, so a word never mixes two
    // classes. Two summary bits per bitmap word, kept in flip-flops, tell
    // whether the word holds any occupied slot and any empty slot. A request
    // finds the lowest useful word from the summary, reads that word, picks
    // the lowest bit and then reads and writes the slot memory.
    localparam int unsigned SIW = $clog2(REGION_BYTES);
    localparam int unsigned BIW = $clog2(scsa_pkg::BM_W);
    localparam int unsigned TOTAL_SLOTS = scsa_pkg::first_slot(REGION_BYTES, NUM_CLASSES);
    localparam int unsigned TW  = scsa_pkg::word_base(REGION_BYTES, NUM_CLASSES);
    localparam int unsigned WIW = (TW > 1) ? $clog2(TW) : 1;
    localparam int unsigned WBW = $clog2(TW + 1);
    localparam int unsigned MW  = scsa_pkg::class_words(REGION_BYTES, 0);
    localparam int unsigned KW  = (MW > 1) ? $clog2(MW) : 1;
    localparam int unsigned CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int unsigned AW  = scsa_pkg::ADDR_W;
    localparam int unsigned BMW = scsa_pkg::BM_W;
    localparam int unsigned NW  = scsa_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECODE = 5'b00100,
        S_LOOKUP = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    // Per-class constants, one entry per class.
    logic [SIW-1:0] cls_slots [NUM_CLASSES];
    logic [SIW-1:0] cls_first [NUM_CLASSES];
    logic [WBW-1:0] cls_wbase [NUM_CLASSES];
    logic [KW:0]    cls_words [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] cls_match;

    state_t state_reg, state_next;
    scsa_pkg::req_t req_reg;
    logic [CW-1:0]  cls_reg, cls_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [WIW-1:0] word_reg, word_next;
    logic [scsa_pkg::STAT_W-1:0] status_reg, status_next;
    logic           use_mem_reg, use_mem_next;
    logic           rsp_valid_reg, rsp_valid_next;
    scsa_pkg::rsp_t rsp_reg;

    logic [SIW-1:0] init_idx_reg, init_idx_next;
    logic [CW-1:0]  init_cls_reg, init_cls_next;
    logic [SIW-1:0] init_j_reg, init_j_next;
    logic [WIW-1:0] init_word_reg, init_word_next;
    logic [AW-1:0]  init_addr_reg, init_addr_next;
    logic [AW-1:0]  init_base_reg, init_base_next;

    logic [TW-1:0]  occ_sum_reg, occ_sum_next;
    logic [TW-1:0]  emp_sum_reg, emp_sum_next;

    // Memories and their ports.
    logic [AW-1:0]  slot_mem [REGION_BYTES];
    logic [AW-1:0]  slot_q;
    logic           slot_we, slot_re;
    logic [SIW-1:0] slot_addr;
    logic [AW-1:0]  slot_wd;

    logic [BMW-1:0] bm_mem [TW];
    logic [BMW-1:0] bm_q;
    logic           bm_we, bm_re;
    logic [WIW-1:0] bm_wa, bm_ra;
    logic [BMW-1:0] bm_wd;

    // Decode and search signals.
    logic           cls_hit;
    logic [CW-1:0]  cls_idx;
    logic           is_null;
    logic [TW-1:0]  sum_sel;
    logic [TW-1:0]  sum_shift;
    logic           word_found;
    logic [KW-1:0]  k_sel;
    logic [NW-1:0]  lk_rem;
    logic [BMW-1:0] lk_mask;
    logic [BMW-1:0] lk_cand;
    logic [BIW-1:0] bit_sel;
    logic [BMW-1:0] new_word;
    logic [NW-1:0]  init_rem;
    logic [BMW-1:0] init_mask;
    logic           rsp_load;

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_cls
        assign cls_slots[g] = SIW'(scsa_pkg::slots_in_class(REGION_BYTES, g));
        assign cls_first[g] = SIW'(scsa_pkg::first_slot(REGION_BYTES, g));
        assign cls_wbase[g] = WBW'(scsa_pkg::word_base(REGION_BYTES, g));
        assign cls_words[g] = (KW + 1)'(scsa_pkg::class_words(REGION_BYTES, g));
        assign cls_match[g] = ({1'b0, req_reg.size_bytes}
                               == (scsa_pkg::SIZE_W + 1)'(64'd1 << (g + 1)));
    end

    // Request decode and the word search over the summary bits.
    always_comb
    begin
        cls_hit = |cls_match;
        cls_idx = '0;
        for (int unsigned c = 0; c < NUM_CLASSES; c++)
        begin
            if (cls_match[c])
            begin
                cls_idx = CW'(c);
            end
        end
        is_null = (req_reg.req_type == scsa_pkg::REQ_FREE) && (req_reg.free_address == '0);

        // An allocate looks for a word with an occupied slot, a free for a
        // word with an empty one.
        sum_sel   = (req_reg.req_type == scsa_pkg::REQ_FREE) ? emp_sum_reg : occ_sum_reg;
        sum_shift = sum_sel >> cls_wbase[cls_idx];
        word_found = 1'b0;
        k_sel = '0;
        for (int k = MW - 1; k >= 0; k--)
        begin
            if (sum_shift[k] && ((KW + 1)'(k) < cls_words[cls_idx]))
            begin
                word_found = 1'b1;
                k_sel = KW'(k);
            end
        end
    end

    // Bit search inside the word that was read.
    always_comb
    begin
        lk_rem  = NW'(cls_slots[cls_reg]) - (NW'(k_reg) << BIW);
        lk_mask = scsa_pkg::mask_from_rem(lk_rem);
        lk_cand = (req_reg.req_type == scsa_pkg::REQ_FREE) ? (~bm_q & lk_mask) : bm_q;
        bit_sel = '0;
        for (int b = BMW - 1; b >= 0; b--)
        begin
            if (lk_cand[b])
            begin
                bit_sel = BIW'(b);
            end
        end
        new_word = bm_q ^ (BMW'(1) << bit_sel);

        init_rem  = NW'(cls_slots[init_cls_reg]) - NW'(init_j_reg);
        init_mask = scsa_pkg::mask_from_rem(init_rem);
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_load  = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        k_next         = k_reg;
        word_next      = word_reg;
        status_next    = status_reg;
        use_mem_next   = use_mem_reg;
        init_idx_next  = init_idx_reg;
        init_cls_next  = init_cls_reg;
        init_j_next    = init_j_reg;
        init_word_next = init_word_reg;
        init_addr_next = init_addr_reg;
        init_base_next = init_base_reg;
        occ_sum_next   = occ_sum_reg;
        emp_sum_next   = emp_sum_reg;

        slot_we   = 1'b0;
        slot_re   = 1'b0;
        slot_addr = init_idx_reg;
        slot_wd   = init_addr_reg;
        bm_we     = 1'b0;
        bm_re     = 1'b0;
        bm_wa     = init_word_reg;
        bm_wd     = init_mask;
        bm_ra     = WIW'(cls_wbase[cls_idx] + WBW'(k_sel));

        case (state_reg)
            S_INIT:
            begin
                // Fill pass: one slot per cycle, and one bitmap word at the
                // first slot of each word, with every existing slot occupied.
                slot_we = 1'b1;
                if ((NW'(init_j_reg) & NW'(BMW - 1)) == '0)
                begin
                    bm_we = 1'b1;
                    init_word_next = init_word_reg + 1'b1;
                end
                if (init_j_reg == cls_slots[init_cls_reg] - 1'b1)
                begin
                    init_cls_next  = init_cls_reg + 1'b1;
                    init_j_next    = '0;
                    init_base_next = init_base_reg + AW'(REGION_BYTES);
                    init_addr_next = init_base_reg + AW'(REGION_BYTES);
                end
                else
                begin
                    init_j_next    = init_j_reg + 1'b1;
                    init_addr_next = init_addr_reg + (AW'(2) << init_cls_reg);
                end
                init_idx_next = init_idx_reg + 1'b1;
                if (init_idx_reg == SIW'(TOTAL_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cls_next     = cls_idx;
                k_next       = k_sel;
                word_next    = bm_ra;
                use_mem_next = 1'b0;
                if (is_null)
                begin
                    status_next = scsa_pkg::ST_NULL;
                    state_next  = S_FINISH;
                end
                else if (!cls_hit)
                begin
                    status_next = scsa_pkg::ST_NO_CLASS;
                    state_next  = S_FINISH;
                end
                else if (!word_found)
                begin
                    status_next = (req_reg.req_type == scsa_pkg::REQ_FREE)
                                  ? scsa_pkg::ST_FULL : scsa_pkg::ST_EXHAUSTED;
                    state_next  = S_FINISH;
                end
                else
                begin
                    bm_re       = 1'b1;
                    status_next = scsa_pkg::ST_OK;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                // The slot memory reads the old address while it writes the
                // new one, so an allocate gets its address and empties the
                // slot in the same cycle.
                slot_addr = SIW'(32'(cls_first[cls_reg]) + (32'(k_reg) << BIW) + 32'(bit_sel));
                slot_we   = 1'b1;
                if (req_reg.req_type == scsa_pkg::REQ_FREE)
                begin
                    slot_wd      = req_reg.free_address;
                    use_mem_next = 1'b0;
                end
                else
                begin
                    slot_wd      = '0;
                    slot_re      = 1'b1;
                    use_mem_next = 1'b1;
                end
                bm_we = 1'b1;
                bm_wa = word_reg;
                bm_wd = new_word;
                occ_sum_next[word_reg] = |new_word;
                emp_sum_next[word_reg] = |(~new_word & lk_mask);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cls_reg       <= '0;
            k_reg         <= '0;
            word_reg      <= '0;
            status_reg    <= scsa_pkg::ST_OK;
            use_mem_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            init_idx_reg  <= '0;
            init_cls_reg  <= '0;
            init_j_reg    <= '0;
            init_word_reg <= '0;
            init_addr_reg <= scsa_pkg::SLAB_BASE;
            init_base_reg <= scsa_pkg::SLAB_BASE;
            // After the fill pass every bitmap word holds occupied slots
            // only, so the summary starts in that state.
            occ_sum_reg   <= '1;
            emp_sum_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cls_reg       <= cls_next;
            k_reg         <= k_next;
            word_reg      <= word_next;
            status_reg    <= status_next;
            use_mem_reg   <= use_mem_next;
            rsp_valid_reg <= rsp_valid_next;
            init_idx_reg  <= init_idx_next;
            init_cls_reg  <= init_cls_next;
            init_j_reg    <= init_j_next;
            init_word_reg <= init_word_next;
            init_addr_reg <= init_addr_next;
            init_base_reg <= init_base_next;
            occ_sum_reg   <= occ_sum_next;
            emp_sum_reg   <= emp_sum_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.alloc_address <= use_mem_reg ? slot_q : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_addr] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_q <= slot_mem[slot_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_wa] <= bm_wd;
        end
        if (bm_re)
        begin
            bm_q <= bm_mem[bm_ra];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/scsa_checker.sv =====
module scsa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input scsa_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input scsa_pkg::rsp_t rsp
);

    // A stalled response beat holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // Every failed request reports a null address.
    a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != scsa_pkg::ST_OK) |-> rsp.alloc_address == '0)
        else $error("failed request returned an address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= scsa_pkg::ST_NULL)
        else $error("undefined status code");

    // Requests are served one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

endmodule

bind size_class_slot_allocator_top scsa_checker u_scsa_checker (.*);

// ===== bench/size_class_slot_allocator_top_test.sv =====
module size_class_slot_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLASS_COUNT  = scsa_pkg::NUM_CLASSES_DEF;
    localparam int unsigned REGION       = scsa_pkg::REGION_BYTES_DEF;
    localparam int          CLK_PERIOD   = 8;
    localparam int          RESET_CYCLES = 11;
    localparam int          RANDOM_BEATS = 530;
    // The last stretch of random beats runs with no idling on either side.
    localparam int          CALM_TAIL    = 60;
    localparam int          DRAIN_CYCLES = 12;
    // The watchdog limit leaves a wide margin over the fill pass after reset and,
    // for each beat, its send gap, its time in the block and its response stall.
    localparam int          CYCLE_LIMIT  = 200000;

    typedef enum {MIX_ALLOC, MIX_FREE, MIX_EVEN} traffic_mix_e;

    // One request beat waiting for the driver.  A held beat is not launched
    // until every response already owed has come back.  A calm beat turns off
    // idling on both sides while it is the latest beat launched.
    typedef struct {
        scsa_pkg::req_t beat;
        bit             hold;
        bit             calm;
    } pending_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    scsa_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    scsa_pkg::rsp_t rsp;

    pending_beat_t  request_queue[$];
    scsa_pkg::rsp_t owed_responses[$];

    // Copy of the slot store: one run of slots per class, class 0 first.
    logic [scsa_pkg::ADDR_W-1:0] slot_mem [REGION];

    int  beats_sent = 0;
    int  beats_back = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  calm_phase = 1'b0;

    size_class_slot_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Works out the response to one request and applies it to the slot copy.
    // A null free is caught before the size is looked at.  Otherwise the size
    // must be exactly 2^(c+1) for some class c; the class is then scanned from
    // its lowest slot for a full slot (allocate) or an empty one (free).
    function automatic scsa_pkg::rsp_t predict_response(scsa_pkg::req_t beat);
        scsa_pkg::rsp_t outcome;
        int             cls;
        int             c;
        int unsigned    base;
        int unsigned    count;
        int unsigned    j;
        bit             done;
        outcome.alloc_address = '0;
        outcome.status = scsa_pkg::ST_OK;
        cls = -1;
        if (beat.req_type == scsa_pkg::REQ_FREE && beat.free_address == '0)
        begin
            outcome.status = scsa_pkg::ST_NULL;
        end
        else
        begin
            for (c = 0; c < CLASS_COUNT; c++)
            begin
                if (int'(beat.size_bytes) == (1 << (c + 1)))
                begin
                    cls = c;
                end
            end
            if (cls < 0)
            begin
                outcome.status = scsa_pkg::ST_NO_CLASS;
            end
            else
            begin
                base = 0;
                for (c = 0; c < cls; c++)
                begin
                    base += REGION >> (c + 1);
                end
                count = REGION >> (cls + 1);
                done = 1'b0;
                for (j = 0; j < count && !done && base + j < REGION; j++)
                begin
                    if (beat.req_type == scsa_pkg::REQ_ALLOC && slot_mem[base + j] != '0)
                    begin
                        outcome.alloc_address = slot_mem[base + j];
                        slot_mem[base + j] = '0;
                        done = 1'b1;
                    end
                    else if (beat.req_type == scsa_pkg::REQ_FREE && slot_mem[base + j] == '0)
                    begin
                        slot_mem[base + j] = beat.free_address;
                        done = 1'b1;
                    end
                end
                if (!done)
                begin
                    outcome.status = (beat.req_type == scsa_pkg::REQ_ALLOC)
                                     ? scsa_pkg::ST_EXHAUSTED : scsa_pkg::ST_FULL;
                end
            end
        end
        return outcome;
    endfunction

    task automatic queue_beat(logic kind, int unsigned size, logic [scsa_pkg::ADDR_W-1:0] addr,
                              bit hold, bit calm);
        pending_beat_t item;
        item.beat.req_type = kind;
        item.beat.size_bytes = size[scsa_pkg::SIZE_W-1:0];
        item.beat.free_address = addr;
        item.hold = hold;
        item.calm = calm;
        request_queue.push_back(item);
    endtask

    // Request driver.  A beat accepted at this edge is predicted right away,
    // so the owed responses stay in acceptance order.  The valid level for the
    // next cycle is settled in a variable and assigned once.
    logic          next_valid;
    bit            accepted_now;
    pending_beat_t next_item;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            accepted_now = req_valid && req_ready;
            next_valid = req_valid && !req_ready;
            if (accepted_now)
            begin
                owed_responses.push_back(predict_response(req));
                beats_sent <= beats_sent + 1;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (request_queue.size() != 0)
                begin
                    // A held beat waits until the block has answered all it
                    // owes; the counters are the values from before this edge.
                    if (!request_queue[0].hold || (!accepted_now && beats_sent == beats_back))
                    begin
                        next_item = request_queue.pop_front();
                        req <= next_item.beat;
                        calm_phase <= next_item.calm;
                        next_valid = 1'b1;
                        if (!next_item.calm && $urandom_range(0, 3) == 0)
                        begin
                            send_gap = $urandom_range(1, 9);
                        end
                    end
                end
            end
            req_valid <= next_valid;
        end
    end

    // Response monitor.  Every accepted response beat is checked against the
    // oldest owed response, field by field.  The ready line stalls in bursts
    // unless the current traffic is calm.
    scsa_pkg::rsp_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                beats_back <= beats_back + 1;
                if (owed_responses.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected response beat: addr %h status %0d",
                                 rsp.alloc_address, rsp.status);
                    end
                    mismatches++;
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (rsp.alloc_address !== want.alloc_address || rsp.status !== want.status)
                    begin
                        if (mismatches < 10)
                        begin
                            $display(
                                "response %0d: want addr %h status %0d, got addr %h status %0d",
                                beats_back, want.alloc_address, want.status,
                                rsp.alloc_address, rsp.status);
                        end
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 4) == 0)
                begin
                    stall_left = $urandom_range(1, 9);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Builds the whole request list, releases reset, then waits for the
    // traffic to drain and reports.
    initial
    begin
        int            c;
        int unsigned   j;
        int unsigned   base;
        int unsigned   size;
        int unsigned   slots;
        int            made;
        int            seg_len;
        int            k;
        int            cls;
        int            roll;
        traffic_mix_e  mix;
        bit            seg_calm;
        logic          kind;
        logic [scsa_pkg::ADDR_W-1:0] addr;

        // Carved layout after reset: class c slot j holds
        // base + c * region + j * size.
        for (j = 0; j < REGION; j++)
        begin
            slot_mem[j] = '0;
        end
        base = 0;
        for (c = 0; c < CLASS_COUNT; c++)
        begin
            for (j = 0; j < (REGION >> (c + 1)) && base + j < REGION; j++)
            begin
                slot_mem[base + j] = scsa_pkg::SLAB_BASE + c * REGION + j * (1 << (c + 1));
            end
            base += REGION >> (c + 1);
        end

        // Directed beats.  The single-slot top class covers exhaustion, reuse
        // after a free and a free into a full class.
        queue_beat(scsa_pkg::REQ_ALLOC, 2, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 1024, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 1024, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_FREE, 1024, 32'h1234_5678, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_FREE, 1024, 32'hCAFE_0001, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 1024, 32'h0000_0000, 1'b0, 1'b0);
        // A null free beats an unmatched size.
        queue_beat(scsa_pkg::REQ_FREE, 0, 32'h0000_0000, 1'b0, 1'b0);
        // Sizes that match no class: zero, all ones, one past the top class,
        // odd, and a single byte.
        queue_beat(scsa_pkg::REQ_FREE, 4095, 32'h2000_0010, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 0, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 4095, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 2048, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 3, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 1, 32'h0000_0000, 1'b0, 1'b0);
        // Refill the smallest class, then overflow it.
        queue_beat(scsa_pkg::REQ_FREE, 2, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_FREE, 2, 32'h2000_0000, 1'b0, 1'b0);
        // The same address freed twice is stored twice and handed out twice.
        queue_beat(scsa_pkg::REQ_ALLOC, 512, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 512, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_FREE, 512, 32'h0BAD_0200, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_FREE, 512, 32'h0BAD_0200, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 512, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 512, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_ALLOC, 512, 32'h0000_0000, 1'b0, 1'b0);
        queue_beat(scsa_pkg::REQ_FREE, 4, 32'h0000_0000, 1'b0, 1'b0);

        // Random traffic in segments that lean toward allocation or toward
        // freeing, so small classes run dry and fill up again and again.
        // Most beats name a real class, weighted toward the classes with few
        // slots; a few carry arbitrary sizes or null addresses.
        made = 0;
        while (made < RANDOM_BEATS)
        begin
            seg_len = $urandom_range(10, 40);
            mix = traffic_mix_e'($urandom_range(0, 2));
            seg_calm = ($urandom_range(0, 4) == 0);
            for (k = 0; k < seg_len && made < RANDOM_BEATS; k++)
            begin
                case (mix)
                    MIX_ALLOC:
                        kind = ($urandom_range(0, 9) < 8) ? scsa_pkg::REQ_ALLOC
                                                          : scsa_pkg::REQ_FREE;
                    MIX_FREE:
                        kind = ($urandom_range(0, 9) < 2) ? scsa_pkg::REQ_ALLOC
                                                          : scsa_pkg::REQ_FREE;
                    default:
                        kind = ($urandom_range(0, 1) == 0) ? scsa_pkg::REQ_ALLOC
                                                           : scsa_pkg::REQ_FREE;
                endcase
                roll = $urandom_range(0, 99);
                addr = $urandom;
                if (roll < 8)
                begin
                    size = $urandom_range(0, 4095);
                end
                else
                begin
                    cls = (roll < 60) ? $urandom_range(4, CLASS_COUNT - 1)
                                      : $urandom_range(0, CLASS_COUNT - 1);
                    size = 1 << (cls + 1);
                    slots = REGION >> (cls + 1);
                    if (kind == scsa_pkg::REQ_FREE && slots > 0 && $urandom_range(0, 1) == 0)
                    begin
                        addr = scsa_pkg::SLAB_BASE + cls * REGION
                               + $urandom_range(0, slots - 1) * size;
                    end
                end
                if (kind == scsa_pkg::REQ_FREE && $urandom_range(0, 19) == 0)
                begin
                    addr = '0;
                end
                // The first random beat, and a few more, wait for the block
                // to go quiet before they are sent.
                queue_beat(kind, size, addr,
                           made == 0 || $urandom_range(0, 49) == 0,
                           seg_calm || made >= RANDOM_BEATS - CALM_TAIL);
                made++;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled on the falling edge so every process of the rising edge
        // has already run.
        @(negedge clk);
        while (request_queue.size() != 0 || req_valid || beats_back != beats_sent)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && owed_responses.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
